/* design/kslb_pkg.sv */
// kslb_pkg: shared types, constants and scancode translation tables for the
// keyboard scancode line buffer. No dependencies.
package kslb_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int AVAIL_W    = (PTR_W > 8) ? PTR_W : 8;
  localparam int OPQ_DEPTH  = 2;
  localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] CH_BACKSPACE    = 8'h08;
  localparam logic [7:0] CH_NEWLINE      = 8'h0A;

  typedef enum logic [1:0] {
    MODE_COOKED   = 2'd0,
    MODE_RAW      = 2'd1,
    MODE_SCANCODE = 2'd2,
    MODE_QUIET    = 2'd3
  } mode_e;

  typedef enum logic [0:0] {
    CMD_SCAN = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_READ  = 3'd1,
    OP_SCAN  = 3'd2,
    OP_BS    = 3'd3,
    OP_STORE = 3'd4
  } op_kind_e;

  typedef struct packed {
    logic [0:0] cmd;
    logic [7:0] scan_code;
  } in_word_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [7:0] bytes_available;
  } out_word_t;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
    logic       echo;
    logic       commit;
  } op_t;

  typedef struct packed {
    logic valid;
    logic full;
  } opq_status_t;

  function automatic logic [7:0] plain_char(input logic [6:0] c);
    logic [7:0] r;
    r = 8'h00;
    case (c)
      7'h01: r = 8'h1B; 7'h02: r = 8'h31; 7'h03: r = 8'h32; 7'h04: r = 8'h33;
      7'h05: r = 8'h34; 7'h06: r = 8'h35; 7'h07: r = 8'h36; 7'h08: r = 8'h37;
      7'h09: r = 8'h38; 7'h0A: r = 8'h39; 7'h0B: r = 8'h30; 7'h0C: r = 8'h2D;
      7'h0D: r = 8'h3D; 7'h0E: r = 8'h08; 7'h0F: r = 8'h09;
      7'h10: r = 8'h71; 7'h11: r = 8'h77; 7'h12: r = 8'h65; 7'h13: r = 8'h72;
      7'h14: r = 8'h74; 7'h15: r = 8'h79; 7'h16: r = 8'h75; 7'h17: r = 8'h69;
      7'h18: r = 8'h6F; 7'h19: r = 8'h70; 7'h1A: r = 8'h5B; 7'h1B: r = 8'h5D;
      7'h1C: r = 8'h0A;
      7'h1E: r = 8'h61; 7'h1F: r = 8'h73; 7'h20: r = 8'h64; 7'h21: r = 8'h66;
      7'h22: r = 8'h67; 7'h23: r = 8'h68; 7'h24: r = 8'h6A; 7'h25: r = 8'h6B;
      7'h26: r = 8'h6C; 7'h27: r = 8'h3B; 7'h28: r = 8'h27; 7'h29: r = 8'h60;
      7'h2B: r = 8'h5C; 7'h2C: r = 8'h7A; 7'h2D: r = 8'h78; 7'h2E: r = 8'h63;
      7'h2F: r = 8'h76; 7'h30: r = 8'h62; 7'h31: r = 8'h6E; 7'h32: r = 8'h6D;
      7'h33: r = 8'h2C; 7'h34: r = 8'h2E; 7'h35: r = 8'h2F; 7'h37: r = 8'h2A;
      7'h39: r = 8'h20; 7'h4A: r = 8'h2D; 7'h4E: r = 8'h2B;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] shift_char(input logic [6:0] c);
    logic [7:0] r;
    r = 8'h00;
    case (c)
      7'h01: r = 8'h1B; 7'h02: r = 8'h21; 7'h03: r = 8'h40; 7'h04: r = 8'h23;
      7'h05: r = 8'h24; 7'h06: r = 8'h25; 7'h07: r = 8'h5E; 7'h08: r = 8'h26;
      7'h09: r = 8'h2A; 7'h0A: r = 8'h28; 7'h0B: r = 8'h29; 7'h0C: r = 8'h5F;
      7'h0D: r = 8'h2B; 7'h0E: r = 8'h08; 7'h0F: r = 8'h09;
      7'h10: r = 8'h51; 7'h11: r = 8'h57; 7'h12: r = 8'h45; 7'h13: r = 8'h52;
      7'h14: r = 8'h54; 7'h15: r = 8'h59; 7'h16: r = 8'h55; 7'h17: r = 8'h49;
      7'h18: r = 8'h4F; 7'h19: r = 8'h50; 7'h1A: r = 8'h7B; 7'h1B: r = 8'h7D;
      7'h1C: r = 8'h0A;
      7'h1E: r = 8'h41; 7'h1F: r = 8'h53; 7'h20: r = 8'h44; 7'h21: r = 8'h46;
      7'h22: r = 8'h47; 7'h23: r = 8'h48; 7'h24: r = 8'h4A; 7'h25: r = 8'h4B;
      7'h26: r = 8'h4C; 7'h27: r = 8'h3A; 7'h28: r = 8'h22; 7'h29: r = 8'h7E;
      7'h2B: r = 8'h7C; 7'h2C: r = 8'h5A; 7'h2D: r = 8'h58; 7'h2E: r = 8'h43;
      7'h2F: r = 8'h56; 7'h30: r = 8'h42; 7'h31: r = 8'h4E; 7'h32: r = 8'h4D;
      7'h33: r = 8'h3C; 7'h34: r = 8'h3E; 7'h35: r = 8'h3F; 7'h37: r = 8'h2A;
      7'h39: r = 8'h20; 7'h4A: r = 8'h2D; 7'h4E: r = 8'h2B;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

/* design/kslb_ram.sv */
// kslb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module kslb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/kslb_front.sv */
// kslb_front: accepts input words, tracks the shift keys, translates scancodes
// and classifies each word into a back-end operation. Depends on kslb_pkg.
module kslb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kslb_pkg::mode_e   mode_i,
  input  logic              push_i,
  input  kslb_pkg::in_word_t in_word_i,
  input  logic              opq_full_i,
  output logic              full_o,
  output logic              op_valid_o,
  output kslb_pkg::op_t     op_o
);

  logic       lshift_q, lshift_d;
  logic       rshift_q, rshift_d;
  logic       accept;
  logic       track;
  logic [7:0] sc;
  logic [7:0] plain, shifted, ch;

  assign full_o     = opq_full_i;
  assign accept     = push_i && !opq_full_i;
  assign op_valid_o = accept;
  assign sc         = in_word_i.scan_code;
  assign track      = (in_word_i.cmd == kslb_pkg::CMD_SCAN) &&
                      (mode_i != kslb_pkg::MODE_SCANCODE);

  always_comb begin
    lshift_d = lshift_q;
    rshift_d = rshift_q;
    if (track) begin
      if (sc == kslb_pkg::SC_LSHIFT_MAKE) begin
        lshift_d = 1'b1;
      end else if (sc == kslb_pkg::SC_RSHIFT_MAKE) begin
        rshift_d = 1'b1;
      end else if (sc == kslb_pkg::SC_LSHIFT_BREAK) begin
        lshift_d = 1'b0;
      end else if (sc == kslb_pkg::SC_RSHIFT_BREAK) begin
        rshift_d = 1'b0;
      end
    end
  end

  assign plain   = kslb_pkg::plain_char(sc[6:0]);
  assign shifted = kslb_pkg::shift_char(sc[6:0]);
  assign ch      = (lshift_d || rshift_d) ? shifted : plain;

  always_comb begin
    op_o.kind   = kslb_pkg::OP_NONE;
    op_o.data   = ch;
    op_o.echo   = 1'b0;
    op_o.commit = 1'b0;
    if (in_word_i.cmd == kslb_pkg::CMD_READ) begin
      op_o.kind = kslb_pkg::OP_READ;
    end else if (mode_i == kslb_pkg::MODE_SCANCODE) begin
      op_o.kind = kslb_pkg::OP_SCAN;
      op_o.data = sc;
    end else if (sc[7] || plain == 8'h00) begin
      op_o.kind = kslb_pkg::OP_NONE;
    end else if (mode_i == kslb_pkg::MODE_COOKED && ch == kslb_pkg::CH_BACKSPACE) begin
      op_o.kind = kslb_pkg::OP_BS;
    end else begin
      op_o.kind   = kslb_pkg::OP_STORE;
      op_o.echo   = (mode_i == kslb_pkg::MODE_COOKED);
      op_o.commit = (mode_i == kslb_pkg::MODE_RAW) || (ch == kslb_pkg::CH_NEWLINE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lshift_q <= 1'b0;
      rshift_q <= 1'b0;
    end else if (accept) begin
      lshift_q <= lshift_d;
      rshift_q <= rshift_d;
    end
  end

endmodule

/* design/kslb_opq.sv */
// kslb_opq: short operation queue between front and back end.
// Depends on kslb_pkg.
module kslb_opq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  kslb_pkg::op_t         op_i,
  input  logic                  pop_i,
  output kslb_pkg::op_t         op_o,
  output kslb_pkg::opq_status_t status_o
);

  kslb_pkg::op_t                    ent_q [kslb_pkg::OPQ_DEPTH];
  logic [kslb_pkg::OPQ_PTR_W-1:0]   wptr_q, wptr_d;
  logic [kslb_pkg::OPQ_PTR_W-1:0]   rptr_q, rptr_d;
  logic [kslb_pkg::OPQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                             do_pop;

  assign status_o.valid = (cnt_q != '0);
  assign status_o.full  = (cnt_q == kslb_pkg::OPQ_CNT_W'(kslb_pkg::OPQ_DEPTH));
  assign op_o           = ent_q[rptr_q];
  assign do_pop         = pop_i && status_o.valid;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == kslb_pkg::OPQ_PTR_W'(kslb_pkg::OPQ_DEPTH - 1)) ? '0 :
               wptr_q + kslb_pkg::OPQ_PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == kslb_pkg::OPQ_PTR_W'(kslb_pkg::OPQ_DEPTH - 1)) ? '0 :
               rptr_q + kslb_pkg::OPQ_PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + kslb_pkg::OPQ_CNT_W'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - kslb_pkg::OPQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* design/kslb_back.sv */
// kslb_back: executes operations on the ring (pointers, stores, reads) and
// holds the result word for the consumer. Depends on kslb_pkg and kslb_ram.
module kslb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kslb_pkg::opq_status_t opq_i,
  input  kslb_pkg::op_t         op_i,
  output logic                  op_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output kslb_pkg::out_word_t   out_word_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  localparam int PW = kslb_pkg::PTR_W;
  localparam int AW = kslb_pkg::AVAIL_W;

  state_e              state_q, state_d;
  logic [PW-1:0]       rd_q, rd_d, cm_q, cm_d, ed_q, ed_d;
  logic                out_valid_q, out_valid_d;
  kslb_pkg::out_word_t out_q, out_d, res;
  logic                out_set;
  logic                ram_we;
  logic [7:0]          ram_rdata;
  logic [PW-1:0]       avail;
  logic [AW-1:0]       avail_w;

  kslb_ram #(
    .WIDTH(8),
    .DEPTH(kslb_pkg::RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ed_q),
    .wdata_i(op_i.data),
    .raddr_i(rd_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    rd_d     = rd_q;
    cm_d     = cm_q;
    ed_d     = ed_q;
    ram_we   = 1'b0;
    op_pop_o = 1'b0;
    out_set  = 1'b0;
    res      = '0;
    case (state_q)
      S_IDLE: begin
        if (opq_i.valid && !out_valid_q) begin
          op_pop_o = 1'b1;
          case (op_i.kind)
            kslb_pkg::OP_READ: begin
              if (rd_q != cm_q) begin
                rd_d    = rd_q + PW'(1);
                state_d = S_READ;
              end else begin
                out_set = 1'b1;
              end
            end
            kslb_pkg::OP_SCAN: begin
              ram_we  = 1'b1;
              ed_d    = ed_q + PW'(1);
              cm_d    = ed_q + PW'(1);
              if ((ed_q + PW'(2)) == rd_q) begin
                rd_d = rd_q + PW'(1);
              end
              out_set = 1'b1;
            end
            kslb_pkg::OP_BS: begin
              if (rd_q != ed_q) begin
                ed_d           = ed_q - PW'(1);
                res.echo_valid = 1'b1;
                res.echo_char  = kslb_pkg::CH_BACKSPACE;
              end
              out_set = 1'b1;
            end
            kslb_pkg::OP_STORE: begin
              ram_we = 1'b1;
              ed_d   = ed_q + PW'(1);
              if (op_i.commit) begin
                cm_d = ed_q + PW'(1);
              end
              if (op_i.echo) begin
                res.echo_valid = 1'b1;
                res.echo_char  = op_i.data;
              end
              out_set = 1'b1;
            end
            default: begin
              out_set = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res.read_valid = 1'b1;
        res.read_byte  = ram_rdata;
        out_set        = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign avail   = cm_d - rd_d;
  assign avail_w = AW'(avail);

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_set) begin
      out_valid_d           = 1'b1;
      out_d                 = res;
      out_d.bytes_available = (avail_w > AW'(255)) ? 8'hFF : avail_w[7:0];
    end else if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_word_o = out_q;

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_q        <= '0;
      cm_q        <= '0;
      ed_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      cm_q        <= cm_d;
      ed_q        <= ed_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* design/keyboard_scancode_line_buffer.sv */
// Path: an accepted word goes into the operation queue; the back end then
// registers its result word, and a read that finds a byte also passes the
// ring RAM's registered read port and the S_READ state. The back end holds
// a single result word until popped and takes no new operation meanwhile.
// Reset: pointers, shift flags and mode_q clear; ring contents stay undefined.
module keyboard_scancode_line_buffer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  kslb_pkg::in_word_t  in_word_i,
  output logic                empty,
  input  logic                pop,
  output kslb_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_wdata_i
);

  kslb_pkg::mode_e       mode_q;
  logic                  op_push;
  kslb_pkg::op_t         op_in, op_head;
  logic                  op_pop;
  kslb_pkg::opq_status_t opq_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= kslb_pkg::MODE_COOKED;
    end else if (cfg_we_i) begin
      mode_q <= kslb_pkg::mode_e'(cfg_wdata_i);
    end
  end

  kslb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .push_i    (push),
    .in_word_i (in_word_i),
    .opq_full_i(opq_st.full),
    .full_o    (full),
    .op_valid_o(op_push),
    .op_o      (op_in)
  );

  kslb_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .op_i    (op_in),
    .pop_i   (op_pop),
    .op_o    (op_head),
    .status_o(opq_st)
  );

  kslb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .opq_i     (opq_st),
    .op_i      (op_head),
    .op_pop_o  (op_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .out_word_o(out_word_o)
  );

endmodule

/* design/kslb_checker.sv */
// kslb_checker: port-level assertions for the line buffer, bound to the top.
// Depends on kslb_pkg and keyboard_scancode_line_buffer.
module kslb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input kslb_pkg::out_word_t out_word_o
);

  a_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result word dropped while stalled");

  a_word_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  a_echo_or_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(out_word_o.echo_valid && out_word_o.read_valid))
    else $error("echo and read in one word");

  a_echo_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_word_o.echo_valid |-> out_word_o.echo_char == 8'h00)
    else $error("echo char without echo");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_word_o.read_valid |-> out_word_o.read_byte == 8'h00)
    else $error("read byte without read");

endmodule

bind keyboard_scancode_line_buffer kslb_checker u_kslb_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .out_word_o(out_word_o)
);
